// ===== hw/rtl/grc_pkg.sv =====
package grc_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;

  // Configuration register indexes
  localparam logic [2:0] CfgBoxX   = 3'd0;
  localparam logic [2:0] CfgBoxY   = 3'd1;
  localparam logic [2:0] CfgBoxZ   = 3'd2;
  localparam logic [2:0] CfgPeriod = 3'd3;
  localparam logic [2:0] CfgRadSq  = 3'd4;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        depth;
    logic               set_end;
  } pt_in_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [31:0]        depth_max;
    logic [6:0]         member_count;
    logic [6:0]         cluster_total;
    logic               final_cluster;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            load_we;
    logic            sel_init;
    logic            rd_issue;
    logic            rd_claim;
    logic [IdxW-1:0] rd_idx;
    logic            seed_take;
    logic            emit;
  } grc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CntW-1:0] point_cnt;
    logic            pipe_busy;
    logic            all_assigned;
  } grc_sts_t;

endpackage

// ===== hw/rtl/grc_ctrl.sv =====
module grc_ctrl
  import grc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     set_end_i,
  input  grc_sts_t sts_i,
  output grc_cmd_t cmd_o,
  output logic     busy_o,
  output logic     res_vld_o
);

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_SELECT = 4'b0010,
    ST_CLAIM  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            scan_more;

  assign scan_more = (idx_q < sts_i.point_cnt);

  // Sequence load, seed search, claim scan and result word
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.rd_idx = idx_q[IdxW-1:0];
    case (state_q)
      ST_LOAD: begin
        if (start_i) begin
          cmd_o.load_we = 1'b1;
          if (set_end_i) begin
            cmd_o.sel_init = 1'b1;
            idx_d   = '0;
            state_d = ST_SELECT;
          end
        end
      end
      ST_SELECT: begin
        if (scan_more) begin
          cmd_o.rd_issue = 1'b1;
          idx_d = idx_q + CntW'(1);
        end else if (!sts_i.pipe_busy) begin
          cmd_o.seed_take = 1'b1;
          idx_d   = '0;
          state_d = ST_CLAIM;
        end
      end
      ST_CLAIM: begin
        if (scan_more) begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_claim = 1'b1;
          idx_d = idx_q + CntW'(1);
        end else if (!sts_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        idx_d = '0;
        if (sts_i.all_assigned) begin
          state_d = ST_LOAD;
        end else begin
          cmd_o.sel_init = 1'b1;
          state_d = ST_SELECT;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o    = (state_q != ST_LOAD);
  assign res_vld_o = (state_q == ST_EMIT);

endmodule

// ===== hw/rtl/grc_datapath.sv =====
module grc_datapath
  import grc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pt_in_t      pt_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  grc_cmd_t    cmd_i,
  output grc_sts_t    sts_o,
  output res_t        res_o
);

  // Configuration
  logic [30:0] box_x_q, box_y_q, box_z_q;
  logic [2:0]  period_q;
  logic [63:0] rad_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q  <= 31'd1048576;
      box_y_q  <= 31'd1048576;
      box_z_q  <= 31'd1048576;
      period_q <= 3'd7;
      rad_sq_q <= 64'd6184752906;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBoxX:   box_x_q  <= cfg_data_i[30:0];
        CfgBoxY:   box_y_q  <= cfg_data_i[30:0];
        CfgBoxZ:   box_z_q  <= cfg_data_i[30:0];
        CfgPeriod: period_q <= cfg_data_i[2:0];
        CfgRadSq:  rad_sq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Point memories
  logic [31:0] mem_x [MaxPoints];
  logic [31:0] mem_y [MaxPoints];
  logic [31:0] mem_z [MaxPoints];
  logic [31:0] mem_d [MaxPoints];
  logic [CntW-1:0] cnt_q;
  logic            wr_en;

  assign wr_en = cmd_i.load_we && (cnt_q < CntW'(MaxPoints));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[cnt_q[IdxW-1:0]] <= pt_i.pos_x;
      mem_y[cnt_q[IdxW-1:0]] <= pt_i.pos_y;
      mem_z[cnt_q[IdxW-1:0]] <= pt_i.pos_z;
      mem_d[cnt_q[IdxW-1:0]] <= pt_i.depth;
    end
  end

  logic [31:0]     rd_x_q, rd_y_q, rd_z_q, rd_d_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            sel_vld_q, clm_vld_q;

  // Registered read of all four memories
  always_ff @(posedge clk_i) begin
    rd_x_q   <= mem_x[cmd_i.rd_idx];
    rd_y_q   <= mem_y[cmd_i.rd_idx];
    rd_z_q   <= mem_z[cmd_i.rd_idx];
    rd_d_q   <= mem_d[cmd_i.rd_idx];
    rd_idx_q <= cmd_i.rd_idx;
  end

  // Seed search state
  logic [31:0]     seed_x_q, seed_y_q, seed_z_q, seed_d_q;
  logic [IdxW-1:0] seed_idx_q;
  logic            found_q;
  logic [MaxPoints-1:0] asg_q;
  logic            sel_better;

  assign sel_better = sel_vld_q && !asg_q[rd_idx_q] && (!found_q || (rd_d_q > seed_d_q));

  always_ff @(posedge clk_i) begin
    if (sel_better) begin
      seed_x_q   <= rd_x_q;
      seed_y_q   <= rd_y_q;
      seed_z_q   <= rd_z_q;
      seed_d_q   <= rd_d_q;
      seed_idx_q <= rd_idx_q;
    end
  end

  // Fold one axis to its minimum image when that axis is periodic
  function automatic logic signed [33:0] fold(input logic [31:0] a, input logic [31:0] b,
                                              input logic [30:0] len, input logic per);
    logic signed [33:0] d, l;
    d = 34'(signed'(b)) - 34'(signed'(a));
    l = signed'({3'b000, len});
    fold = d;
    if (per) begin
      if ((d <<< 1) >= l) begin
        fold = d - l;
      end else if ((d <<< 1) <= -l) begin
        fold = d + l;
      end
    end
  endfunction

  // Square one component, saturate at a magnitude of 2^32 or more
  function automatic logic [63:0] sq_sat(input logic signed [33:0] d);
    logic [33:0] m;
    m = d[33] ? 34'(-d) : 34'(d);
    if (m[33:32] != 2'b00) begin
      sq_sat = '1;
    end else begin
      sq_sat = 64'(m[31:0]) * 64'(m[31:0]);
    end
  endfunction

  // Distance pipeline: fold, square, two saturating adds
  logic signed [33:0] dx_q, dy_q, dz_q;
  logic [63:0]        sx_q, sy_q, sz_q, sz2_q, sxy_q, sum_q;
  logic [IdxW-1:0]    idx2_q, idx3_q, idx4_q, idx5_q;
  logic               vld2_q, vld3_q, vld4_q, vld5_q;
  logic [64:0]        add1, add2;

  assign add1 = {1'b0, sx_q} + {1'b0, sy_q};
  assign add2 = {1'b0, sxy_q} + {1'b0, sz2_q};

  always_ff @(posedge clk_i) begin
    dx_q   <= fold(seed_x_q, rd_x_q, box_x_q, period_q[0]);
    dy_q   <= fold(seed_y_q, rd_y_q, box_y_q, period_q[1]);
    dz_q   <= fold(seed_z_q, rd_z_q, box_z_q, period_q[2]);
    idx2_q <= rd_idx_q;
    sx_q   <= sq_sat(dx_q);
    sy_q   <= sq_sat(dy_q);
    sz_q   <= sq_sat(dz_q);
    idx3_q <= idx2_q;
    sxy_q  <= add1[64] ? '1 : add1[63:0];
    sz2_q  <= sz_q;
    idx4_q <= idx3_q;
    sum_q  <= add2[64] ? '1 : add2[63:0];
    idx5_q <= idx4_q;
  end

  logic            claim_hit;
  logic [6:0]      mem_cnt_q;
  logic [CntW-1:0] asg_cnt_q;
  logic [6:0]      clus_q;

  assign claim_hit = vld5_q && !asg_q[idx5_q] && (sum_q <= rad_sq_q);

  // Control state: valids, flags and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      clm_vld_q <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      found_q   <= 1'b0;
      asg_q     <= '0;
      cnt_q     <= '0;
      mem_cnt_q <= '0;
      asg_cnt_q <= '0;
      clus_q    <= '0;
    end else begin
      sel_vld_q <= cmd_i.rd_issue && !cmd_i.rd_claim;
      clm_vld_q <= cmd_i.rd_issue && cmd_i.rd_claim;
      vld2_q    <= clm_vld_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      vld5_q    <= vld4_q;
      if (wr_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.sel_init) begin
        found_q <= 1'b0;
      end else if (sel_better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.seed_take) begin
        asg_q[seed_idx_q] <= 1'b1;
        asg_cnt_q         <= asg_cnt_q + CntW'(1);
        mem_cnt_q         <= 7'd1;
      end else if (claim_hit) begin
        asg_q[idx5_q] <= 1'b1;
        asg_cnt_q     <= asg_cnt_q + CntW'(1);
        mem_cnt_q     <= mem_cnt_q + 7'd1;
      end
      if (cmd_i.emit) begin
        if (sts_o.all_assigned) begin
          asg_q     <= '0;
          asg_cnt_q <= '0;
          cnt_q     <= '0;
          clus_q    <= '0;
        end else begin
          clus_q <= clus_q + 7'd1;
        end
      end
    end
  end

  assign sts_o.point_cnt    = cnt_q;
  assign sts_o.pipe_busy    = sel_vld_q | clm_vld_q | vld2_q | vld3_q | vld4_q | vld5_q;
  assign sts_o.all_assigned = (asg_cnt_q == cnt_q);

  // Result word from the seed registers and the cluster counters
  assign res_o.center_x      = seed_x_q;
  assign res_o.center_y      = seed_y_q;
  assign res_o.center_z      = seed_z_q;
  assign res_o.depth_max     = seed_d_q;
  assign res_o.member_count  = mem_cnt_q;
  assign res_o.final_cluster = sts_o.all_assigned;
  assign res_o.cluster_total = sts_o.all_assigned ? (clus_q + 7'd1) : 7'd0;

endmodule

// ===== hw/rtl/greedy_radius_clustering.sv =====
// Points load one word per cycle while busy is low; the word with set_end closes the set.
// Per cluster: a seed search over the n held points, a claim scan through the distance
// pipeline (fold, square, two saturating adds) and a result word, all on one read port.
// Results appear for one cycle on res_vld_o and the receiver cannot stall them.
// Reset clears control state and restores register defaults; no clearing pass is needed.
module greedy_radius_clustering
  import grc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pt_in_t      pt_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        res_vld_o,
  output res_t        res_o
);

  grc_cmd_t cmd;
  grc_sts_t sts;

  grc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .set_end_i (pt_i.set_end),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .res_vld_o (res_vld_o)
  );

  grc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (pt_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule
